>>> rtl/route_table_engine_top_assert.svh
// assertion macros for the route table engine checker
// used by rte_checker; needs aclk and aresetn in scope
`ifndef ROUTE_TABLE_ENGINE_TOP_ASSERT_SVH
`define ROUTE_TABLE_ENGINE_TOP_ASSERT_SVH

// same-cycle implication, idle during reset
`define RTE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rte check failed");

// next-cycle implication, idle during reset
`define RTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rte check failed");

// next-cycle implication, also checked across reset
`define RTE_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("rte check failed");

`endif

>>> rtl/rte_pkg.sv
// shared types, codes and helper functions of the route table engine
// no dependencies
package rte_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // command codes on the input transaction
    localparam logic [3:0] CMD_LOOKUP  = 4'd0;
    localparam logic [3:0] CMD_USABLE  = 4'd1;
    localparam logic [3:0] CMD_UPDATE  = 4'd2;
    localparam logic [3:0] CMD_REFRESH = 4'd3;
    localparam logic [3:0] CMD_INV_NH  = 4'd4;
    localparam logic [3:0] CMD_INV_REP = 4'd5;
    localparam logic [3:0] CMD_PURGE   = 4'd6;
    localparam logic [3:0] CMD_DEL_IF  = 4'd7;
    localparam logic [3:0] CMD_CLEAR   = 4'd8;

    // result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_MISS = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;
    localparam logic [1:0] STAT_DONE = 2'd3;

    typedef enum logic [3:0] {
        OP_LOOKUP, OP_USABLE, OP_UPDATE, OP_REFRESH, OP_INV_NH,
        OP_INV_REP, OP_PURGE, OP_DEL_IF, OP_CLEAR, OP_BAD
    } op_t;

    typedef struct packed {
        logic [3:0]  command;
        logic [31:0] now;
        logic [31:0] dest_addr;
        logic [31:0] next_hop;
        logic [7:0]  hop_count;
        logic [31:0] seq_no;
        logic [31:0] expiry_time;
        logic [31:0] lifetime;
        logic [3:0]  iface_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_dest;
        logic [31:0] out_next_hop;
        logic [7:0]  out_hop_count;
        logic [31:0] out_seq_no;
        logic        out_seq_valid;
        logic        out_route_valid;
        logic [31:0] out_expiry;
        logic [3:0]  out_iface;
        logic        last;
    } out_item_t;

    // classified transaction passed from front to back
    typedef struct packed {
        op_t      op;
        in_item_t item;
    } q_item_t;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] nh;
        logic [7:0]  hops;
        logic [31:0] seq;
        logic        seq_known;
        logic        valid;
        logic [31:0] expiry;
        logic [3:0]  iface;
    } entry_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // a fresher than b: signed difference positive
    function automatic logic seq_fresher(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic out_item_t entry_out(input logic [1:0] st, input entry_t e,
                                            input logic lst);
        out_item_t o;
        o.status          = st;
        o.out_dest        = e.dest;
        o.out_next_hop    = e.nh;
        o.out_hop_count   = e.hops;
        o.out_seq_no      = e.seq;
        o.out_seq_valid   = e.seq_known;
        o.out_route_valid = e.valid;
        o.out_expiry      = e.expiry;
        o.out_iface       = e.iface;
        o.last            = lst;
        return o;
    endfunction

    function automatic out_item_t blank_out(input logic [1:0] st, input logic [31:0] d,
                                            input logic lst);
        out_item_t o;
        o          = '0;
        o.status   = st;
        o.out_dest = d;
        o.last     = lst;
        return o;
    endfunction

endpackage

>>> rtl/route_table_engine_top.sv
// route table engine top: front classifier, two-entry queue, table sequencer
// path: front register and queue, then a read (ST_RD) and an evaluate (ST_EV) step per slot up
//   to the match, then ST_ACT forms the result; clear and unknown commands skip the slot walk
// walks: every slot is read and evaluated, and each next-hop invalidation hit waits in ST_OUT for the result port
// throughput: one transaction in work in the back stage, up to three more held in front
// reset: synchronous active low, table empty, delete_period 15000
module route_table_engine_top import rte_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic    f_valid, f_ready;
    q_item_t f_data;
    logic    q_valid, q_ready;
    q_item_t q_data;

    assign cfg_ready = 1'b1;

    rte_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_data  (f_data)
    );

    rte_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    rte_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> rtl/rte_front.sv
// front stage: accepts input transactions and classifies the command
// depends on rte_pkg
module rte_front import rte_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     f_valid,
    input  logic     f_ready,
    output q_item_t  f_data
);

    logic    fv_reg, fv_next;
    q_item_t fd_reg, fd_next;
    op_t     op_c;

    // command decode
    always_comb begin
        case (s_data.command)
            CMD_LOOKUP:  op_c = OP_LOOKUP;
            CMD_USABLE:  op_c = OP_USABLE;
            CMD_UPDATE:  op_c = OP_UPDATE;
            CMD_REFRESH: op_c = OP_REFRESH;
            CMD_INV_NH:  op_c = OP_INV_NH;
            CMD_INV_REP: op_c = OP_INV_REP;
            CMD_PURGE:   op_c = OP_PURGE;
            CMD_DEL_IF:  op_c = OP_DEL_IF;
            CMD_CLEAR:   op_c = OP_CLEAR;
            default:     op_c = OP_BAD;
        endcase
    end

    assign s_ready = !fv_reg || f_ready;
    assign f_valid = fv_reg;
    assign f_data  = fd_reg;

    // holding register toward the queue
    always_comb begin
        fv_next = fv_reg;
        fd_next = fd_reg;
        if (fv_reg && f_ready) begin
            fv_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            fv_next      = 1'b1;
            fd_next.op   = op_c;
            fd_next.item = s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else begin
            fv_reg <= fv_next;
        end
        fd_reg <= fd_next;
    end

endmodule

>>> rtl/rte_queue.sv
// two-entry queue between front and back
// depends on rte_pkg
module rte_queue import rte_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  q_item_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output q_item_t out_data
);

    q_item_t    buf_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = buf_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count
    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            buf_reg[wp_reg] <= in_data;
        end
    end

endmodule

>>> rtl/rte_back.sv
// back stage: route table storage and the slot-walking command sequencer
// depends on rte_pkg
module rte_back import rte_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  q_item_t     q_data,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_EV   = 5'b00100,
        ST_ACT  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    op_t                    op_reg, op_next;
    in_item_t               item_reg, item_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   found_reg, found_next;
    logic                   free_found_reg, free_found_next;
    logic                   done_reg, done_next;
    entry_t                 hit_reg, hit_next;
    logic [TABLE_DEPTH-1:0] used_reg, used_next;
    logic [31:0]            dp_reg;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg, m_data_next;

    // table storage
    entry_t           mem [TABLE_DEPTH];
    entry_t           rd_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t           mem_wd;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[idx_reg];
    end

    // command sequencer
    always_comb begin
        entry_t      e;
        entry_t      ne;
        logic        used;
        logic        at_end;
        logic        cur_ok;
        logic        accept;
        logic [31:0] now;
        logic [31:0] till_time;
        logic [31:0] ex;

        state_next      = state_reg;
        op_next         = op_reg;
        item_next       = item_reg;
        idx_next        = idx_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        done_next       = done_reg;
        hit_next        = hit_reg;
        used_next       = used_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        q_ready         = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = idx_reg;
        mem_wd          = rd_reg;

        e         = rd_reg;
        ne        = rd_reg;
        used      = used_reg[idx_reg];
        at_end    = (idx_reg == IDX_W'(TABLE_DEPTH - 1));
        now       = item_reg.now;
        till_time = sat_add(item_reg.now, item_reg.lifetime);
        cur_ok    = hit_reg.valid && (hit_reg.expiry > now);
        accept    = 1'b0;
        ex        = item_reg.expiry_time;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_ready         = 1'b1;
                    op_next         = q_data.op;
                    item_next       = q_data.item;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    done_next       = 1'b0;
                    if (q_data.op == OP_CLEAR || q_data.op == OP_BAD) begin
                        state_next = ST_ACT;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_EV;
            end
            ST_EV: begin
                // default: move on to the next slot
                if (at_end) begin
                    state_next = ST_ACT;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
                case (op_reg)
                    OP_INV_NH: begin
                        if (used && e.valid && e.nh == item_reg.next_hop) begin
                            if (e.seq_known) begin
                                ne.seq = e.seq + 32'd1;
                            end
                            ne.valid     = 1'b0;
                            ne.expiry    = sat_add(now, dp_reg);
                            mem_we       = 1'b1;
                            mem_wd       = ne;
                            m_valid_next = 1'b1;
                            m_data_next  = entry_out(STAT_OK, ne, 1'b0);
                            done_next    = at_end;
                            idx_next     = idx_reg;
                            state_next   = ST_OUT;
                        end
                    end
                    OP_PURGE: begin
                        if (used && !(e.expiry > now)) begin
                            if (e.valid) begin
                                ne.valid  = 1'b0;
                                ne.expiry = sat_add(e.expiry, dp_reg);
                                mem_we    = 1'b1;
                                mem_wd    = ne;
                                if (!(ne.expiry > now)) begin
                                    used_next[idx_reg] = 1'b0;
                                end
                            end else begin
                                used_next[idx_reg] = 1'b0;
                            end
                        end
                    end
                    OP_DEL_IF: begin
                        if (used && e.iface == item_reg.iface_index) begin
                            used_next[idx_reg] = 1'b0;
                        end
                    end
                    default: begin
                        // keyed search: stop at the matching destination
                        if (used && e.dest == item_reg.dest_addr) begin
                            found_next   = 1'b1;
                            hit_idx_next = idx_reg;
                            hit_next     = e;
                            state_next   = ST_ACT;
                            idx_next     = idx_reg;
                        end else if (!used && !free_found_reg) begin
                            free_found_next = 1'b1;
                            free_idx_next   = idx_reg;
                        end
                    end
                endcase
            end
            ST_ACT: begin
                state_next   = ST_OUT;
                m_valid_next = 1'b1;
                mem_wa       = found_reg ? hit_idx_reg : free_idx_reg;
                ne           = hit_reg;
                case (op_reg)
                    OP_LOOKUP, OP_USABLE: begin
                        if (!found_reg || (op_reg == OP_USABLE && !cur_ok)) begin
                            m_data_next = blank_out(STAT_MISS, 32'd0, 1'b1);
                        end else begin
                            m_data_next = entry_out(STAT_OK, hit_reg, 1'b1);
                        end
                    end
                    OP_UPDATE: begin
                        ne.dest      = item_reg.dest_addr;
                        ne.nh        = item_reg.next_hop;
                        ne.hops      = item_reg.hop_count;
                        ne.seq       = item_reg.seq_no;
                        ne.seq_known = 1'b1;
                        ne.valid     = 1'b1;
                        ne.iface     = item_reg.iface_index;
                        if (!found_reg) begin
                            ne.expiry = item_reg.expiry_time;
                            if (!free_found_reg) begin
                                m_data_next = blank_out(STAT_FULL, item_reg.dest_addr, 1'b1);
                            end else begin
                                mem_we                  = 1'b1;
                                mem_wd                  = ne;
                                used_next[free_idx_reg] = 1'b1;
                                m_data_next             = entry_out(STAT_OK, ne, 1'b1);
                            end
                        end else begin
                            accept = !hit_reg.seq_known
                                || seq_fresher(item_reg.seq_no, hit_reg.seq)
                                || (item_reg.seq_no == hit_reg.seq
                                    && (!cur_ok || item_reg.hop_count < hit_reg.hops));
                            if (cur_ok && hit_reg.expiry > ex) begin
                                ex = hit_reg.expiry;
                            end
                            ne.expiry = ex;
                            if (!accept) begin
                                m_data_next = entry_out(STAT_MISS, hit_reg, 1'b1);
                            end else begin
                                mem_we      = 1'b1;
                                mem_wd      = ne;
                                m_data_next = entry_out(STAT_OK, ne, 1'b1);
                            end
                        end
                    end
                    OP_REFRESH: begin
                        if (!found_reg) begin
                            ne.dest      = item_reg.dest_addr;
                            ne.nh        = item_reg.dest_addr;
                            ne.hops      = 8'd1;
                            ne.seq       = 32'd0;
                            ne.seq_known = 1'b0;
                            ne.valid     = 1'b1;
                            ne.expiry    = till_time;
                            ne.iface     = item_reg.iface_index;
                            if (!free_found_reg) begin
                                m_data_next = blank_out(STAT_FULL, item_reg.dest_addr, 1'b1);
                            end else begin
                                mem_we                  = 1'b1;
                                mem_wd                  = ne;
                                used_next[free_idx_reg] = 1'b1;
                                m_data_next             = entry_out(STAT_OK, ne, 1'b1);
                            end
                        end else begin
                            if (!(cur_ok && hit_reg.nh == item_reg.dest_addr
                                  && hit_reg.hops == 8'd1)) begin
                                ne.iface = item_reg.iface_index;
                                ne.nh    = item_reg.dest_addr;
                                ne.hops  = 8'd1;
                                ne.valid = 1'b1;
                            end
                            if (!cur_ok || till_time > hit_reg.expiry) begin
                                ne.expiry = till_time;
                            end
                            mem_we      = 1'b1;
                            mem_wd      = ne;
                            m_data_next = entry_out(cur_ok ? STAT_MISS : STAT_OK, ne, 1'b1);
                        end
                    end
                    OP_INV_REP: begin
                        if (!found_reg || !hit_reg.valid || hit_reg.nh != item_reg.next_hop) begin
                            m_data_next = blank_out(STAT_MISS, 32'd0, 1'b1);
                        end else begin
                            if (!hit_reg.seq_known || seq_fresher(item_reg.seq_no, hit_reg.seq)) begin
                                ne.seq       = item_reg.seq_no;
                                ne.seq_known = 1'b1;
                            end
                            ne.valid    = 1'b0;
                            ne.expiry   = sat_add(now, dp_reg);
                            mem_we      = 1'b1;
                            mem_wd      = ne;
                            m_data_next = entry_out(STAT_OK, ne, 1'b1);
                        end
                    end
                    OP_BAD: begin
                        m_data_next = blank_out(STAT_MISS, 32'd0, 1'b1);
                    end
                    default: begin
                        // walk commands and clear close with a finished transaction
                        if (op_reg == OP_CLEAR) begin
                            used_next = '0;
                        end
                        m_data_next = blank_out(STAT_DONE, 32'd0, 1'b1);
                    end
                endcase
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_data_reg.last) begin
                        state_next = ST_IDLE;
                    end else if (done_reg) begin
                        state_next = ST_ACT;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
            dp_reg      <= 32'd15000;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                dp_reg <= cfg_data;
            end
        end
        op_reg         <= op_next;
        item_reg       <= item_next;
        idx_reg        <= idx_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        found_reg      <= found_next;
        free_found_reg <= free_found_next;
        done_reg       <= done_next;
        hit_reg        <= hit_next;
        m_data_reg     <= m_data_next;
    end

endmodule

>>> rtl/rte_checker.sv
// port-level checker for the route table engine, bound to the top level
// depends on rte_pkg and route_table_engine_top_assert.svh
`include "route_table_engine_top_assert.svh"

module rte_checker import rte_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a stalled result transaction stays offered
    `RTE_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid)
    // no result comes out of reset
    `RTE_ASSERT_RST(a_rst_quiet, !aresetn, !m_valid)
    // the walk-finished transaction always closes the command
    `RTE_ASSERT_NOW(a_done_last, m_valid && m_data.status == STAT_DONE, m_data.last)
    // only invalidation hits come out before the closing transaction
    `RTE_ASSERT_NOW(a_mid_ok, m_valid && !m_data.last, m_data.status == STAT_OK)

endmodule

bind route_table_engine_top rte_checker u_rte_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

>>> test/tb_route_table_engine_top.sv
// testbench for route_table_engine_top: queue-fed driver, clocked monitor, table predictor
// depends on rte_pkg and route_table_engine_top
`timescale 1ns / 1ps

module tb_route_table_engine_top;
    import rte_pkg::*;

    localparam int DEPTH = TABLE_DEPTH;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    route_table_engine_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predicted table state
    logic        tbl_used [DEPTH];
    entry_t      tbl_ent [DEPTH];
    logic [31:0] keep_period;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    int        fail_count;
    int        result_count;
    int        sent_count;
    int        send_gap;
    int        recv_gap;

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // append to the tail of the two queues
    function automatic void add_expected(out_item_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void add_pending(in_item_t it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic newer_seq(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 0) && !d[31];
    endfunction

    function automatic out_item_t blank_res(logic [1:0] st, logic [31:0] d, logic lst);
        out_item_t o;
        o = '0;
        o.status = st;
        o.out_dest = d;
        o.last = lst;
        return o;
    endfunction

    function automatic out_item_t slot_res(logic [1:0] st, int s, logic lst);
        out_item_t o;
        o.status = st;
        o.out_dest = tbl_ent[s].dest;
        o.out_next_hop = tbl_ent[s].nh;
        o.out_hop_count = tbl_ent[s].hops;
        o.out_seq_no = tbl_ent[s].seq;
        o.out_seq_valid = tbl_ent[s].seq_known;
        o.out_route_valid = tbl_ent[s].valid;
        o.out_expiry = tbl_ent[s].expiry;
        o.out_iface = tbl_ent[s].iface;
        o.last = lst;
        return o;
    endfunction

    function automatic int find_dest(logic [31:0] d);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_used[i] && tbl_ent[i].dest == d) return i;
        return -1;
    endfunction

    function automatic int first_free();
        for (int i = 0; i < DEPTH; i++)
            if (!tbl_used[i]) return i;
        return -1;
    endfunction

    function automatic logic is_usable(int s, logic [31:0] now);
        return tbl_ent[s].valid && tbl_ent[s].expiry > now;
    endfunction

    task automatic put_slot(int s, logic [31:0] d, logic [31:0] nh, logic [7:0] h,
                            logic [31:0] sq, logic kn, logic [31:0] ex, logic [3:0] ifc);
        tbl_used[s] = 1'b1;
        tbl_ent[s].dest = d;
        tbl_ent[s].nh = nh;
        tbl_ent[s].hops = h;
        tbl_ent[s].seq = sq;
        tbl_ent[s].seq_known = kn;
        tbl_ent[s].valid = 1'b1;
        tbl_ent[s].expiry = ex;
        tbl_ent[s].iface = ifc;
    endtask

    // apply one command to the predicted table and queue its route results
    task automatic predict_route_op(in_item_t it);
        int s;
        logic ok;
        logic acc;
        logic [31:0] ex;
        logic [31:0] till;
        case (it.command)
            CMD_LOOKUP, CMD_USABLE: begin
                s = find_dest(it.dest_addr);
                if (s < 0 || (it.command == CMD_USABLE && !is_usable(s, it.now)))
                    add_expected(blank_res(STAT_MISS, 0, 1'b1));
                else
                    add_expected(slot_res(STAT_OK, s, 1'b1));
            end
            CMD_UPDATE: begin
                s = find_dest(it.dest_addr);
                if (s < 0) begin
                    s = first_free();
                    if (s < 0) begin
                        add_expected(blank_res(STAT_FULL, it.dest_addr, 1'b1));
                    end else begin
                        put_slot(s, it.dest_addr, it.next_hop, it.hop_count, it.seq_no,
                                 1'b1, it.expiry_time, it.iface_index);
                        add_expected(slot_res(STAT_OK, s, 1'b1));
                    end
                end else begin
                    ok = is_usable(s, it.now);
                    acc = !tbl_ent[s].seq_known || newer_seq(it.seq_no, tbl_ent[s].seq) ||
                          (it.seq_no == tbl_ent[s].seq &&
                           (!ok || it.hop_count < tbl_ent[s].hops));
                    if (!acc) begin
                        add_expected(slot_res(STAT_MISS, s, 1'b1));
                    end else begin
                        ex = it.expiry_time;
                        if (ok && tbl_ent[s].expiry > ex) ex = tbl_ent[s].expiry;
                        put_slot(s, it.dest_addr, it.next_hop, it.hop_count, it.seq_no,
                                 1'b1, ex, it.iface_index);
                        add_expected(slot_res(STAT_OK, s, 1'b1));
                    end
                end
            end
            CMD_REFRESH: begin
                till = add_sat(it.now, it.lifetime);
                s = find_dest(it.dest_addr);
                if (s < 0) begin
                    s = first_free();
                    if (s < 0) begin
                        add_expected(blank_res(STAT_FULL, it.dest_addr, 1'b1));
                    end else begin
                        put_slot(s, it.dest_addr, it.dest_addr, 8'd1, 0, 1'b0, till,
                                 it.iface_index);
                        add_expected(slot_res(STAT_OK, s, 1'b1));
                    end
                end else begin
                    ok = is_usable(s, it.now);
                    if (ok && tbl_ent[s].nh == it.dest_addr && tbl_ent[s].hops == 8'd1) begin
                        if (till > tbl_ent[s].expiry) tbl_ent[s].expiry = till;
                        add_expected(slot_res(STAT_MISS, s, 1'b1));
                    end else begin
                        tbl_ent[s].iface = it.iface_index;
                        tbl_ent[s].nh = it.dest_addr;
                        tbl_ent[s].hops = 8'd1;
                        if (!ok || till > tbl_ent[s].expiry) tbl_ent[s].expiry = till;
                        tbl_ent[s].valid = 1'b1;
                        add_expected(slot_res(ok ? STAT_MISS : STAT_OK, s, 1'b1));
                    end
                end
            end
            CMD_INV_NH: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (tbl_used[i] && tbl_ent[i].valid && tbl_ent[i].nh == it.next_hop) begin
                        if (tbl_ent[i].seq_known) tbl_ent[i].seq = tbl_ent[i].seq + 1;
                        tbl_ent[i].valid = 1'b0;
                        tbl_ent[i].expiry = add_sat(it.now, keep_period);
                        add_expected(slot_res(STAT_OK, i, 1'b0));
                    end
                end
                add_expected(blank_res(STAT_DONE, 0, 1'b1));
            end
            CMD_INV_REP: begin
                s = find_dest(it.dest_addr);
                if (s < 0 || !tbl_ent[s].valid || tbl_ent[s].nh != it.next_hop) begin
                    add_expected(blank_res(STAT_MISS, 0, 1'b1));
                end else begin
                    if (!tbl_ent[s].seq_known || newer_seq(it.seq_no, tbl_ent[s].seq)) begin
                        tbl_ent[s].seq = it.seq_no;
                        tbl_ent[s].seq_known = 1'b1;
                    end
                    tbl_ent[s].valid = 1'b0;
                    tbl_ent[s].expiry = add_sat(it.now, keep_period);
                    add_expected(slot_res(STAT_OK, s, 1'b1));
                end
            end
            CMD_PURGE: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (tbl_used[i] && tbl_ent[i].expiry <= it.now) begin
                        if (tbl_ent[i].valid) begin
                            tbl_ent[i].valid = 1'b0;
                            tbl_ent[i].expiry = add_sat(tbl_ent[i].expiry, keep_period);
                        end
                        if (tbl_ent[i].expiry <= it.now) tbl_used[i] = 1'b0;
                    end
                end
                add_expected(blank_res(STAT_DONE, 0, 1'b1));
            end
            CMD_DEL_IF: begin
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_used[i] && tbl_ent[i].iface == it.iface_index) tbl_used[i] = 1'b0;
                add_expected(blank_res(STAT_DONE, 0, 1'b1));
            end
            CMD_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) tbl_used[i] = 1'b0;
                add_expected(blank_res(STAT_DONE, 0, 1'b1));
            end
            default: add_expected(blank_res(STAT_MISS, 0, 1'b1));
        endcase
    endtask

    // driver: one transaction at a time from the pending queue, random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= $urandom_range(0, 12);
        end else if (s_valid && s_ready) begin
            predict_route_op(s_data);
            sent_count <= sent_count + 1;
            s_valid <= 1'b0;
            send_gap <= $urandom_range(0, 12);
        end else if (!s_valid && pending_items.size() > 0) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
            end
        end
    end

    // monitor: random stalls, compare against oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    out_item_t e;
                    e = expected_results.pop_front();
                    if (e !== m_data) begin
                        $display("%0t: result mismatch, expected %h, actual %h",
                                 $time, e, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
                recv_gap <= $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // address pools so that keys collide often
    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0;
            5: return $urandom();
            default: return 32'h0A00_0000 + $urandom_range(0, 39);
        endcase
    endfunction

    function automatic in_item_t rand_route_op();
        in_item_t it;
        int r;
        it.now = 32'd1000 + $urandom_range(0, 40000);
        if ($urandom_range(0, 15) == 0) it.now = $urandom();
        it.dest_addr = pick_addr();
        it.next_hop = 32'h0B00_0000 + $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) it.next_hop = $urandom();
        it.hop_count = ($urandom_range(0, 5) == 0) ? 8'($urandom()) : 8'($urandom_range(1, 6));
        it.seq_no = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 6);
        it.expiry_time = it.now + $urandom_range(0, 30000);
        if ($urandom_range(0, 15) == 0) it.expiry_time = $urandom();
        it.lifetime = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 20000);
        it.iface_index = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 2));
        r = $urandom_range(0, 99);
        if (r < 15) it.command = CMD_LOOKUP;
        else if (r < 27) it.command = CMD_USABLE;
        else if (r < 55) it.command = CMD_UPDATE;
        else if (r < 70) it.command = CMD_REFRESH;
        else if (r < 77) it.command = CMD_INV_NH;
        else if (r < 85) it.command = CMD_INV_REP;
        else if (r < 91) it.command = CMD_PURGE;
        else if (r < 95) it.command = CMD_DEL_IF;
        else if (r < 97) it.command = CMD_CLEAR;
        else it.command = 4'($urandom_range(9, 15));
        return it;
    endfunction

    function automatic in_item_t make_op(logic [3:0] c, logic [31:0] now, logic [31:0] d,
                                         logic [31:0] nh, logic [7:0] h, logic [31:0] sq,
                                         logic [31:0] ex, logic [31:0] lf, logic [3:0] ifc);
        in_item_t it;
        it.command = c; it.now = now; it.dest_addr = d; it.next_hop = nh;
        it.hop_count = h; it.seq_no = sq; it.expiry_time = ex; it.lifetime = lf;
        it.iface_index = ifc;
        return it;
    endfunction

    // sample on the falling edge so that the clocked blocks have settled
    task automatic drain_results();
        @(negedge aclk);
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(negedge aclk);
        repeat (2 * DEPTH + 40) @(posedge aclk);
    endtask

    // single config write while idle
    task automatic write_keep_period(logic [31:0] v);
        @(posedge aclk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        keep_period = v;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] periods [4];
        periods = '{32'd0, 32'hFFFF_FFFF, 32'd15000, 32'd500};
        s_valid = 1'b0; m_ready = 1'b0; cfg_valid = 1'b0; cfg_data = '0; s_data = '0;
        aresetn = 1'b0;
        fail_count = 0; result_count = 0; sent_count = 0;
        keep_period = 32'd15000;
        for (int i = 0; i < DEPTH; i++) begin
            tbl_used[i] = 1'b0;
            tbl_ent[i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every command, table full, seq wrap, saturation
        add_pending(make_op(CMD_LOOKUP, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
        add_pending(make_op(CMD_UPDATE, 10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
        add_pending(make_op(CMD_UPDATE, 10, 32'hFFFF_FFFF, 32'h5, 8'h3, 32'h0,
                            100, 0, 1));
        add_pending(make_op(CMD_UPDATE, 10, 32'hFFFF_FFFF, 32'h6, 8'h2, 32'h0,
                            50, 0, 2));
        add_pending(make_op(CMD_USABLE, 20, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
        add_pending(make_op(CMD_REFRESH, 32'hFFFF_FFF0, 32'h7, 0, 0, 0, 0,
                            32'hFFFF_FFFF, 3));
        add_pending(make_op(CMD_REFRESH, 5, 32'h7, 0, 0, 0, 0, 10, 3));
        add_pending(make_op(CMD_REFRESH, 5, 32'hFFFF_FFFF, 0, 0, 0, 0, 10, 4));
        add_pending(make_op(CMD_INV_NH, 32'hFFFF_FF00, 0, 32'h7, 0, 0, 0, 0, 0));
        add_pending(make_op(CMD_INV_REP, 30, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
                            32'h8000_0000, 0, 0, 0));
        add_pending(make_op(CMD_PURGE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0));
        add_pending(make_op(CMD_DEL_IF, 0, 0, 0, 0, 0, 0, 0, 4'hF));
        add_pending(make_op(4'hF, 0, 0, 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < DEPTH + 1; i++)
            add_pending(make_op(CMD_UPDATE, 0, 32'h100 + i, 32'h9, 1, i, 1000, 0, 0));
        add_pending(make_op(CMD_REFRESH, 0, 32'h999, 0, 0, 0, 0, 5, 0));
        add_pending(make_op(CMD_INV_NH, 0, 0, 32'h9, 0, 0, 0, 0, 0));
        add_pending(make_op(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        // hold-off until every expected result is in
        drain_results();

        // random phases across delete_period settings
        for (int p = 0; p < 4; p++) begin
            write_keep_period(periods[p]);
            for (int k = 0; k < 28; k++) add_pending(rand_route_op());
            drain_results();
        end

        $display("ran %0d route commands, %0d results checked, four delete periods",
                 sent_count, result_count);
        if (fail_count == 0)
            $display("route_table_engine_top verification clean");
        else
            $display("route_table_engine_top verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("route_table_engine_top verification failed");
        $finish;
    end

endmodule
